### rtl/m3inv_pkg.sv
`default_nettype none
package m3inv_pkg;
  localparam int EW      = 16;
  localparam int CW      = 2 * EW + 1;     // cofactor width
  localparam int DW      = 49;             // determinant width
  localparam int NUMW    = CW + 24;        // shifted cofactor magnitude
  localparam int QW      = 32;
  localparam int DIV_CYC = 8;
  localparam int STEP    = 7;              // quotient bits per stage
  localparam int QBITS   = DIV_CYC * STEP; // 56, one bit short of NUMW

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  typedef struct packed {
    logic             neg;
    logic [QBITS-1:0] num;
    logic [DW-1:0]    dm;
  } lane_in_t;

  typedef struct packed {
    logic          sat;
    logic [QW-1:0] q;
  } lane_out_t;
endpackage
`default_nettype wire

### rtl/m3inv_lane.sv
`default_nettype none
// One divider lane: restoring division, STEP quotient bits per stage,
// fully pipelined so a new operand pair enters every cycle while en is high.
module m3inv_lane (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire m3inv_pkg::lane_in_t din,
  output m3inv_pkg::lane_out_t     dout
);
  import m3inv_pkg::*;

  logic [DW:0]      rem_r [DIV_CYC+1];
  logic [QBITS-1:0] num_r [DIV_CYC+1];
  logic [DW-1:0]    dm_r  [DIV_CYC+1];
  logic             neg_r [DIV_CYC+1];

  always_comb begin
    rem_r[0] = '0;
    num_r[0] = din.num;
    dm_r[0]  = din.dm;
    neg_r[0] = din.neg;
  end

  for (genvar s = 0; s < DIV_CYC; s++) begin : g_stg
    logic [DW:0]      rem_nxt;
    logic [QBITS-1:0] num_nxt;
    always_comb begin
      logic [DW+1:0] t;
      rem_nxt = rem_r[s];
      num_nxt = num_r[s];
      for (int b = 0; b < STEP; b++) begin
        t = {rem_nxt, num_nxt[QBITS-1]};
        num_nxt = {num_nxt[QBITS-2:0], 1'b0};
        if (t >= {2'b00, dm_r[s]}) begin
          t = t - {2'b00, dm_r[s]};
          num_nxt[0] = 1'b1;
        end
        rem_nxt = t[DW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        num_r[s+1] <= num_nxt;
        dm_r[s+1]  <= dm_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  always_comb begin
    logic [QBITS-1:0] q;
    q = num_r[DIV_CYC];
    dout.sat = 1'b0;
    dout.q   = q[QW-1:0];
    if (neg_r[DIV_CYC]) begin
      if (q > QBITS'(64'h8000_0000)) begin
        dout.sat = 1'b1;
        dout.q   = 32'h8000_0000;
      end else begin
        dout.q = 32'(-q);
      end
    end else if (q > QBITS'(64'h7fff_ffff)) begin
      dout.sat = 1'b1;
      dout.q   = 32'h7fff_ffff;
    end
  end
endmodule
`default_nettype wire

### rtl/m3inv_cof.sv
`default_nettype none
// Cofactors (registered products, then differences) and determinant.
module m3inv_cof (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire m3inv_pkg::elem_t    a [9],
  output m3inv_pkg::cof_t          cof [9],
  output m3inv_pkg::det_t          det
);
  import m3inv_pkg::*;

  localparam int P = 2 * EW;
  localparam int I0 [9] = '{4,1,1,3,0,0,3,0,0};
  localparam int I1 [9] = '{8,8,5,8,8,5,7,7,4};
  localparam int I2 [9] = '{7,7,4,6,6,3,6,6,3};
  localparam int I3 [9] = '{5,2,2,5,2,2,4,1,1};
  localparam logic NG [9] = '{0,1,0,1,0,1,0,1,0};

  logic signed [P-1:0] pa_r [9];
  logic signed [P-1:0] pb_r [9];
  cof_t                cof_r [9];
  elem_t               a1_r [3];
  elem_t               a2_r [3];
  logic signed [DW-1:0] dp_r [3];
  det_t                det_r;
  cof_t                cof2_r [9];
  cof_t                cof3_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pa_r[k] <= a[I0[k]] * a[I1[k]];
        pb_r[k] <= a[I2[k]] * a[I3[k]];
        cof_r[k] <= NG[k] ? CW'(pb_r[k]) - CW'(pa_r[k]) : CW'(pa_r[k]) - CW'(pb_r[k]);
        cof2_r[k] <= cof_r[k];
        cof3_r[k] <= cof2_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        a1_r[k] <= a[k];
        a2_r[k] <= a1_r[k];
        dp_r[k] <= DW'(a2_r[k]) * DW'(cof_r[3*k]);
      end
      det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    end
  end
  assign cof = cof3_r;
  assign det = det_r;
endmodule
`default_nettype wire

### rtl/matrix3x3_inverse.sv
`default_nettype none
// Channel | Dir | tdata fields (low bit first)              | tuser
// in_     | in  | a00..a22, 16 bits each (144 bits)          | -
// out_    | out | inv00..inv22 32b each, determinant 49b (337b, pad to 344) | status 2b
//
// One matrix per cycle while the output is taken. Stages in order: cofactors and
// determinant (m3inv_cof), sign/magnitude split, 8 divider stages (7 quotient bits
// each, nine lanes), merge into the output register.
// rst_n (synchronous) clears the valid pipeline only.
// Stall: the whole pipe holds when the output register is full and not taken.
module matrix3x3_inverse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [343:0]      out_tdata,  // inv00..inv22, determinant, zero pad
  output logic [1:0]        out_tuser   // status
);
  import m3inv_pkg::*;

  localparam int LAT = 4 + 1 + DIV_CYC;

  logic en;
  logic [LAT-1:0] vld_r;
  elem_t a [9];
  cof_t cof [9];
  det_t det;
  lane_in_t li_r [9];
  lane_out_t lo [9];
  det_t det_d_r [DIV_CYC+1];
  logic out_tvalid_r;
  logic [343:0] out_tdata_r;
  logic [1:0] out_tuser_r;
  logic [343:0] out_tdata_nxt;
  logic [1:0] out_tuser_nxt;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  for (genvar k = 0; k < 9; k++) begin : g_in
    assign a[k] = in_tdata[EW*k +: EW];
  end

  m3inv_cof u_cof (.clk, .en, .a, .cof, .det);

  // sign/magnitude split feeding the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        li_r[k].neg <= cof[k][CW-1] ^ det[DW-1];
        li_r[k].num <= QBITS'(cof[k][CW-1] ? -cof[k] : cof[k]) << 24;
        li_r[k].dm  <= det[DW-1] ? DW'(-det) : DW'(det);
      end
      det_d_r[0] <= det;
      for (int s = 0; s < DIV_CYC; s++) det_d_r[s+1] <= det_d_r[s];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3inv_lane u_lane (.clk, .en, .din(li_r[k]), .dout(lo[k]));
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[LAT-2:0], in_tvalid};
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  // singular: everything zero; otherwise lanes, determinant, OR of saturations
  always_comb begin
    logic s;
    s = 1'b0;
    out_tdata_nxt = '0;
    out_tuser_nxt = ST_SING;
    if (det_d_r[DIV_CYC] != '0) begin
      for (int k = 0; k < 9; k++) begin
        out_tdata_nxt[32*k +: 32] = lo[k].q;
        s = s | lo[k].sat;
      end
      out_tdata_nxt[288 +: DW] = det_d_r[DIV_CYC];
      out_tuser_nxt = s ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
endmodule
`default_nettype wire

### rtl/m3inv_chk.sv
`default_nettype none
module m3inv_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [343:0] out_tdata,
  input wire logic [1:0]   out_tuser
);
  import m3inv_pkg::*;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && out_tvalid)
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input blocked while output empty");
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SING |-> out_tdata == '0)
    else $error("singular result not zero");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_SAT) else $error("bad status");
endmodule

bind matrix3x3_inverse m3inv_chk u_chk (.*);
`default_nettype wire
